// ----- hw/rtl/rbc_pkg.sv -----
// Shared types and constants of the run-length byte compressor.
// Used by the front end, the command queue and the back end; depends on nothing.
package rbc_pkg;

   localparam int ByteW     = 8;
   localparam int CountW    = 7;
   localparam int FifoDepth = 4;
   localparam int FifoAw    = $clog2(FifoDepth);
   localparam int FifoCw    = $clog2(FifoDepth + 1);

   // Command codes passed from the front end to the back end.
   localparam logic [1:0] OP_PUSH    = 2'd0;
   localparam logic [1:0] OP_REPEAT  = 2'd1;
   localparam logic [1:0] OP_LITERAL = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [CountW-1:0] count;
      logic [ByteW-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic room_two;
   } fifo_stat_type;

endpackage

// ----- hw/rtl/rbc_front.sv -----
// Front end: accepts raw bytes, tracks the pending run and issues commands.
// Depends on rbc_pkg for the command type and the queue status.
module rbc_front #(
   parameter int MAX_LITERAL = 32,
   parameter int MAX_REPEAT  = 127
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic                  req_tlast,   // end_of_stream
   input  rbc_pkg::fifo_stat_type stat,
   output logic                  push_valid,
   output rbc_pkg::cmd_type      push_cmd
);

   localparam int PcW = $clog2(MAX_LITERAL + 1);

   logic [PcW-1:0]              pc_ff, pc_in;
   logic [rbc_pkg::CountW-1:0]  rc_ff, rc_in;
   logic [rbc_pkg::ByteW-1:0]   last_ff, last_in;
   logic                        second_valid_ff, second_valid_in;
   rbc_pkg::cmd_type            second_cmd_ff, second_cmd_in;
   logic                        accept;
   logic                        c1_valid, c2_valid;
   rbc_pkg::cmd_type            c1, c2;

   function automatic rbc_pkg::cmd_type mk_cmd(input logic [1:0] op,
                                               input logic [rbc_pkg::CountW-1:0] count,
                                               input logic [rbc_pkg::ByteW-1:0] value);
      rbc_pkg::cmd_type c;
      c.op    = op;
      c.count = count;
      c.value = value;
      return c;
   endfunction

   assign req_tready = !second_valid_ff && stat.room_two;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pc_in    = pc_ff;
      rc_in    = rc_ff;
      last_in  = last_ff;
      c1_valid = 1'b0;
      c2_valid = 1'b0;
      c1       = mk_cmd(rbc_pkg::OP_PUSH, '0, req_tdata);
      c2       = mk_cmd(rbc_pkg::OP_PUSH, '0, req_tdata);
      if (req_tlast) begin
         if (pc_ff == PcW'(1)) begin
            c1_valid = 1'b1;
            c1       = mk_cmd(rbc_pkg::OP_REPEAT, rc_ff, last_ff);
         end else if (pc_ff > PcW'(1)) begin
            c1_valid = 1'b1;
            c1       = mk_cmd(rbc_pkg::OP_LITERAL, rbc_pkg::CountW'(pc_ff), last_ff);
         end
         pc_in = '0;
         rc_in = '0;
      end else if (pc_ff == '0) begin
         c1_valid = 1'b1;
         pc_in    = PcW'(1);
         rc_in    = rbc_pkg::CountW'(1);
         last_in  = req_tdata;
      end else if (pc_ff == PcW'(1)) begin
         if (req_tdata == last_ff) begin
            if (rc_ff >= rbc_pkg::CountW'(MAX_REPEAT)) begin
               // A full repeat goes out and the byte starts a fresh run.
               c1_valid = 1'b1;
               c1       = mk_cmd(rbc_pkg::OP_REPEAT, rc_ff, last_ff);
               c2_valid = 1'b1;
               rc_in    = rbc_pkg::CountW'(1);
            end else begin
               rc_in = (rc_ff == '0) ? rbc_pkg::CountW'(2) : rc_ff + rbc_pkg::CountW'(1);
            end
         end else if (rc_ff < rbc_pkg::CountW'(2)) begin
            c1_valid = 1'b1;
            pc_in    = PcW'(2);
            rc_in    = rbc_pkg::CountW'(1);
            last_in  = req_tdata;
         end else begin
            c1_valid = 1'b1;
            c1       = mk_cmd(rbc_pkg::OP_REPEAT, rc_ff, last_ff);
            c2_valid = 1'b1;
            rc_in    = rbc_pkg::CountW'(1);
            last_in  = req_tdata;
         end
      end else begin
         if (req_tdata == last_ff) begin
            // The matching last byte stays behind in the buffer as the repeat value.
            c1_valid = 1'b1;
            c1       = mk_cmd(rbc_pkg::OP_LITERAL,
                              rbc_pkg::CountW'(PcW'(pc_ff - PcW'(1))), last_ff);
            pc_in    = PcW'(1);
            rc_in    = rbc_pkg::CountW'(2);
         end else if (pc_ff >= PcW'(MAX_LITERAL)) begin
            c1_valid = 1'b1;
            c1       = mk_cmd(rbc_pkg::OP_LITERAL, rbc_pkg::CountW'(pc_ff), last_ff);
            c2_valid = 1'b1;
            pc_in    = PcW'(1);
            rc_in    = rbc_pkg::CountW'(1);
            last_in  = req_tdata;
         end else begin
            c1_valid = 1'b1;
            pc_in    = PcW'(pc_ff + PcW'(1));
            last_in  = req_tdata;
         end
      end
   end

   always_comb begin
      second_valid_in = second_valid_ff;
      second_cmd_in   = second_cmd_ff;
      push_valid      = 1'b0;
      push_cmd        = c1;
      if (second_valid_ff) begin
         push_valid      = 1'b1;
         push_cmd        = second_cmd_ff;
         second_valid_in = 1'b0;
      end else if (accept) begin
         push_valid      = c1_valid;
         second_valid_in = c2_valid;
         second_cmd_in   = c2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff           <= '0;
         rc_ff           <= '0;
         second_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pc_ff <= pc_in;
            rc_ff <= rc_in;
         end
         second_valid_ff <= second_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= last_in;
      end
      second_cmd_ff <= second_cmd_in;
   end

endmodule

// ----- hw/rtl/rbc_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
// Depends on rbc_pkg for the command type, depth and status struct.
module rbc_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  rbc_pkg::cmd_type       push_cmd,
   input  logic                   pop,
   output rbc_pkg::cmd_type       head_cmd,
   output rbc_pkg::fifo_stat_type stat
);

   rbc_pkg::cmd_type                entry_ff [rbc_pkg::FifoDepth];
   logic [rbc_pkg::FifoAw-1:0]      wptr_ff, rptr_ff;
   logic [rbc_pkg::FifoCw-1:0]      count_ff, count_in;

   assign head_cmd      = entry_ff[rptr_ff];
   assign stat.empty    = (count_ff == '0);
   assign stat.room_two = (count_ff <= rbc_pkg::FifoCw'(rbc_pkg::FifoDepth - 2));

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + rbc_pkg::FifoCw'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - rbc_pkg::FifoCw'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push_valid) begin
            wptr_ff <= wptr_ff + rbc_pkg::FifoAw'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + rbc_pkg::FifoAw'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/rbc_back.sv -----
// Back end: holds the pending bytes in a ring buffer and emits the coded bytes.
// Depends on rbc_pkg for the command type and command codes.
module rbc_back #(
   parameter int MAX_LITERAL = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rbc_pkg::cmd_type       head_cmd,
   input  rbc_pkg::fifo_stat_type stat,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // out_byte
   output logic                   rsp_tlast    // last_of_run
);

   localparam int BufAw    = $clog2(MAX_LITERAL);
   localparam int BufDepth = 1 << BufAw;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_REP_CNT  = 3'd1;
   localparam logic [2:0] ST_REP_VAL  = 3'd2;
   localparam logic [2:0] ST_LIT_HDR  = 3'd3;
   localparam logic [2:0] ST_LIT_DATA = 3'd4;

   logic [rbc_pkg::ByteW-1:0]   buf_mem [BufDepth];
   logic [rbc_pkg::ByteW-1:0]   rd_data_ff;
   logic [2:0]                  state_ff, state_in;
   logic [BufAw-1:0]            head_ff, head_in, tail_ff, tail_in;
   logic [rbc_pkg::CountW-1:0]  remain_ff, remain_in;
   logic [rbc_pkg::ByteW-1:0]   value_ff, value_in;
   logic                        out_valid_ff, out_valid_in;
   logic [rbc_pkg::ByteW-1:0]   out_data_ff, out_data_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_free, out_load, mem_we;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      remain_in   = remain_ff;
      value_in    = value_ff;
      out_load    = 1'b0;
      out_data_in = out_data_ff;
      out_last_in = 1'b0;
      pop         = 1'b0;
      mem_we      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!stat.empty) begin
               pop       = 1'b1;
               remain_in = head_cmd.count;
               value_in  = head_cmd.value;
               case (head_cmd.op)
                  rbc_pkg::OP_PUSH: begin
                     mem_we  = 1'b1;
                     tail_in = tail_ff + BufAw'(1);
                  end
                  rbc_pkg::OP_REPEAT: begin
                     // The single pending byte is dropped; its value rides in the command.
                     head_in  = head_ff + BufAw'(1);
                     state_in = ST_REP_CNT;
                  end
                  rbc_pkg::OP_LITERAL: begin
                     state_in = ST_LIT_HDR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_REP_CNT: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_data_in = {1'b0, remain_ff};
               state_in    = ST_REP_VAL;
            end
         end
         ST_REP_VAL: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_data_in = value_ff;
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_LIT_HDR: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_data_in = rbc_pkg::ByteW'(9'd256 - 9'(remain_ff));
               state_in    = ST_LIT_DATA;
            end
         end
         ST_LIT_DATA: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_data_in = rd_data_ff;
               out_last_in = (remain_ff == rbc_pkg::CountW'(1));
               head_in     = head_ff + BufAw'(1);
               remain_in   = remain_ff - rbc_pkg::CountW'(1);
               if (remain_ff == rbc_pkg::CountW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      value_ff  <= value_in;
      if (out_load) begin
         out_data_ff <= out_data_in;
         out_last_ff <= out_last_in;
      end
   end

   // The read address follows the next head, so rd_data_ff tracks the oldest byte.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem[tail_ff] <= value_in;
      end
      rd_data_ff <= buf_mem[head_in];
   end

endmodule

// ----- hw/rtl/rle_byte_compressor.sv -----
// Run-length byte compressor. The back end takes each command from the queue while idle;
// a repeat then gives a count byte and a value byte, and a literal of n bytes a header
// byte and then its n bytes. Requests are taken one per cycle while the command queue
// has two free slots; a request that closes a run and starts a new one holds off the
// next request while its second command is pushed.
// Synchronous active-high reset clears the run state, the queue and the output valid.
module rle_byte_compressor #(
   parameter int MAX_LITERAL = 32,
   parameter int MAX_REPEAT  = 127
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tlast,   // end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast    // last_of_run
);

   logic                   push_valid;
   logic                   pop;
   rbc_pkg::cmd_type       push_cmd;
   rbc_pkg::cmd_type       head_cmd;
   rbc_pkg::fifo_stat_type stat;

   rbc_front #(
      .MAX_LITERAL(MAX_LITERAL),
      .MAX_REPEAT (MAX_REPEAT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .stat      (stat),
      .push_valid(push_valid),
      .push_cmd  (push_cmd)
   );

   rbc_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .stat      (stat)
   );

   rbc_back #(
      .MAX_LITERAL(MAX_LITERAL)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .stat      (stat),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// ----- hw/rtl/rbc_checker.sv -----
// Port-level checks for the run-length byte compressor, bound to the top level.
// Depends only on the top level's ports.
module rbc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // Nothing is offered on the result side right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The queue is empty after reset, so the front end is ready at once.
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready right after reset");

   // A stalled result holds its byte and marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // The first byte accepted after reset only opens a run and cannot produce output.
   assert property (@(posedge clock) reset ##1 (req_tvalid && req_tready && !req_tlast)
      |=> !rsp_tvalid)
      else $error("output after the first byte of a stream");

endmodule

bind rle_byte_compressor rbc_checker u_checker (.*);

// ----- dv/rle_byte_compressor_tb.sv -----
// Self-checking testbench for the run-length byte compressor: a scoreboard class
// predicts the coded byte stream while plain tasks drive the request channel and an
// initial block drives the response channel. Depends only on rle_byte_compressor in the RTL.
module rle_byte_compressor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LITERAL_LEN = 32;
   localparam int MAX_REPEAT_LEN  = 127;
   localparam int DRAIN_CYCLES    = 12;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } coded_byte_type;

   // Predicts the coded bytes for each accepted request and checks the responses.
   class rle_coder_model;
      logic [7:0]     held [MAX_LITERAL_LEN];
      bit [5:0]       held_count;
      bit [6:0]       run_len;
      coded_byte_type coded_due [$];
      int unsigned    mismatches;
      int unsigned    requests_seen;
      int unsigned    stream_ends;
      int unsigned    bytes_checked;

      function new();
         held_count    = 0;
         run_len       = 0;
         mismatches    = 0;
         requests_seen = 0;
         stream_ends   = 0;
         bytes_checked = 0;
      endfunction

      function void emit_code(input logic [7:0] code);
         coded_byte_type item;
         item.code = code;
         item.last = 1'b0;
         coded_due = {coded_due, item};
      endfunction

      // Sends the oldest n held bytes as a literal and keeps the remainder.
      function void emit_literal(input int unsigned n);
         int unsigned i;
         emit_code(8'(256 - n));
         for (i = 0; i < n; i++) emit_code(held[i]);
         for (i = 0; i + n < held_count; i++) held[i] = held[i + n];
         held_count = held_count - 6'(n);
         run_len    = (held_count != 0) ? 7'd1 : 7'd0;
      endfunction

      function void emit_repeat();
         emit_code({1'b0, run_len});
         emit_code(held[0]);
         held_count = 0;
         run_len    = 0;
      endfunction

      function void open_run(input logic [7:0] b);
         held[0]    = b;
         held_count = 1;
         run_len    = 1;
      endfunction

      function void note_request(input logic [7:0] b, input logic eos);
         int unsigned mark;
         mark = coded_due.size();
         requests_seen++;
         if (eos) begin
            stream_ends++;
            if (held_count == 1) emit_repeat();
            else if (held_count > 1) emit_literal(held_count);
            held_count = 0;
            run_len    = 0;
         end else if (held_count == 0) begin
            open_run(b);
         end else if (held_count == 1) begin
            if (b == held[0]) begin
               if (run_len >= MAX_REPEAT_LEN) begin
                  emit_repeat();
                  open_run(b);
               end else begin
                  run_len = (run_len == 0) ? 7'd2 : run_len + 7'd1;
               end
            end else if (run_len < 2) begin
               held[1]    = b;
               held_count = 2;
               run_len    = 1;
            end else begin
               emit_repeat();
               open_run(b);
            end
         end else begin
            // A byte matching the newest literal byte turns that byte into a repeat.
            if (b == held[held_count - 1]) begin
               emit_literal(held_count - 1);
               run_len = 2;
            end else if (held_count >= MAX_LITERAL_LEN) begin
               emit_literal(held_count);
               open_run(b);
            end else begin
               held[held_count] = b;
               held_count++;
            end
         end
         if (coded_due.size() > mark) coded_due[coded_due.size() - 1].last = 1'b1;
      endfunction

      function void check_coded_byte(input logic [7:0] code, input logic last);
         coded_byte_type want;
         bytes_checked++;
         if (coded_due.size() == 0) begin
            $display("%0t: unexpected coded byte %02h (last %0b)", $time, code, last);
            mismatches++;
            return;
         end
         want = coded_due.pop_front();
         if (want.code !== code) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.code, code);
            mismatches++;
         end
         if (want.last !== last) begin
            $display("%0t: last_of_run expected %0b, got %0b", $time, want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // data_byte
   logic       req_tlast;   // end_of_stream
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // out_byte
   logic       rsp_tlast;   // last_of_run

   rle_coder_model model = new();
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_off_requests = 0;
   int          requests_sent = 0;
   logic [7:0]  last_data = 8'h00;

   rle_byte_compressor #(
      .MAX_LITERAL(MAX_LITERAL_LEN),
      .MAX_REPEAT (MAX_REPEAT_LEN)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) model.check_coded_byte(rsp_tdata, rsp_tlast);
   end

   // Response side: random back-pressure, plus long hold-offs requested by the stimulus.
   initial begin : receiver
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_requests > holds_served) begin
            holds_served++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #400000;
      $display("Timeout with %0d coded bytes still expected", model.coded_due.size());
      $display("== FAIL ==");
      $finish;
   end

   // Offers one request and returns once it has been accepted.
   task automatic offer_request(input logic [7:0] data_b, input logic eos);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_b;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      model.note_request(data_b, eos);
      requests_sent++;
      if (!eos) last_data = data_b;
   endtask

   task automatic drain_expected();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (model.coded_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_repeat_run(input logic [7:0] value, input int len);
      repeat (len) offer_request(value, 1'b0);
   endtask

   // Each byte differs from the one before it, so the run stays a literal.
   task automatic send_literal_run(input int len);
      logic [7:0] b;
      repeat (len) begin
         do b = 8'($urandom_range(0, 255)); while (b == last_data);
         offer_request(b, 1'b0);
      end
   endtask

   task automatic send_random_segment();
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 8);
            send_repeat_run(8'($urandom_range(0, 255)), len);
         end
         4, 5, 6: begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
            send_literal_run(len);
         end
         7: begin
            // Values from a tiny alphabet so that short repeats and literals interleave.
            repeat ($urandom_range(1, 6)) offer_request(8'($urandom_range(0, 3)), 1'b0);
         end
         8: offer_request(8'($urandom_range(0, 255)), 1'b1);
         default: begin
            send_literal_run($urandom_range(2, 12));
            send_repeat_run(last_data, $urandom_range(1, 5));
         end
      endcase
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      reset      = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests, with no idling on either side.
      offer_request(8'h00, 1'b1);                        // end with nothing pending
      offer_request(8'h00, 1'b0);                        // lone byte at end
      offer_request(8'h00, 1'b1);
      send_repeat_run(8'hFF, 3);
      offer_request(8'h00, 1'b1);
      offer_request(8'h55, 1'b0);
      offer_request(8'hAA, 1'b0);
      offer_request(8'h55, 1'b0);
      offer_request(8'h00, 1'b1);
      offer_request(8'h12, 1'b0);                        // literal closed by a repeat
      send_repeat_run(8'h34, 3);
      offer_request(8'h56, 1'b0);
      offer_request(8'hFF, 1'b1);
      offer_request(8'h80, 1'b0);
      offer_request(8'hA5, 1'b1);                        // data ignored on an end request
      drain_expected();

      send_idle_pct = 6;
      recv_idle_pct = 70;
      send_repeat_run(8'($urandom_range(0, 255)), MAX_REPEAT_LEN + 2);  // repeat full
      send_literal_run(MAX_LITERAL_LEN + 2);                              // literal full
      while (requests_sent < 200) send_random_segment();
      drain_expected();

      send_idle_pct = 70;
      recv_idle_pct = 6;
      while (requests_sent < 290) send_random_segment();
      drain_expected();

      // The receiver stops for a long stretch while requests keep coming.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_requests++;
      send_literal_run(40);
      send_repeat_run(8'h3C, 20);
      while (requests_sent < 370) send_random_segment();
      offer_request(8'h00, 1'b1);
      drain_expected();

      if (model.coded_due.size() != 0) begin
         $display("%0d coded bytes never arrived", model.coded_due.size());
         model.mismatches++;
      end
      $display("Sent %0d requests (%0d stream ends) and checked %0d coded bytes,",
               model.requests_seen, model.stream_ends, model.bytes_checked);
      $display("with full runs, three idle mixes, a long output hold-off and drains.");
      if (model.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- rle_byte_compressor.f -----
hw/rtl/rbc_pkg.sv
hw/rtl/rbc_front.sv
hw/rtl/rbc_cmd_fifo.sv
hw/rtl/rbc_back.sv
hw/rtl/rle_byte_compressor.sv
hw/rtl/rbc_checker.sv
dv/rle_byte_compressor_tb.sv
